[hw/rtl/slor_pkg.sv]
// ----------------------------------------------------------------------------
// slor_pkg
// Shared types, constants and the arctangent table for the orbit rotator.
// ----------------------------------------------------------------------------
package slor_pkg;

    // target angles in 1/256 degree
    localparam logic signed [15:0] ANGLE_LEFT  = -16'sd11520;
    localparam logic signed [15:0] ANGLE_RIGHT =  16'sd11520;
    localparam logic signed [15:0] ANGLE_BACK  = -16'sd23040;
    localparam logic signed [15:0] ANGLE_ZERO  =  16'sd0;

    // hold while |difference| is at most this many units (1/128 degree)
    localparam logic [16:0] DEADBAND_UNITS = 17'd2;

    // slew speed register
    localparam logic [23:0] SLEW_SPEED_RESET = 24'd23040;
    localparam logic        REG_SLEW_SPEED   = 1'b0;

    // cordic setup
    localparam logic [29:0] GAIN_Q30       = 30'd652032874;
    localparam int          CORDIC_STEPS   = 16;
    localparam int          CORDIC_TAB_LEN = 30;
    localparam int          CORDIC_ITERS   =
        (CORDIC_STEPS > CORDIC_TAB_LEN) ? CORDIC_TAB_LEN : CORDIC_STEPS;
    localparam int          IDX_W          = 5;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CORDIC_ITERS - 1);

    // datapath widths
    localparam int DIFF_W = 33;   // eye minus pivot
    localparam int VEC_W  = 36;   // rotated vector with growth margin
    localparam int ANG_W  = 32;   // residual angle in 2^-22 degree

    // top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MOVE,
        ST_ROT,
        ST_OUT
    } t_state;

    // cordic sequencer
    typedef enum logic [2:0] {
        COR_IDLE,
        COR_GAINX,
        COR_GAINY,
        COR_ITER,
        COR_DONE
    } t_cor_state;

    // request to the rotation unit
    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [ANG_W-1:0]  z0;
    } t_cordic_req;

    // response from the rotation unit
    typedef struct packed {
        logic                    done;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
    } t_cordic_rsp;

    // atan(2^-i) in 2^-22 degree, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'sd188743680;
            5'd1:    v = 32'sd111421900;
            5'd2:    v = 32'sd58872272;
            5'd3:    v = 32'sd29884485;
            5'd4:    v = 32'sd15000234;
            5'd5:    v = 32'sd7507429;
            5'd6:    v = 32'sd3754631;
            5'd7:    v = 32'sd1877430;
            5'd8:    v = 32'sd938729;
            5'd9:    v = 32'sd469366;
            5'd10:   v = 32'sd234683;
            5'd11:   v = 32'sd117342;
            5'd12:   v = 32'sd58671;
            5'd13:   v = 32'sd29335;
            5'd14:   v = 32'sd14668;
            5'd15:   v = 32'sd7334;
            5'd16:   v = 32'sd3667;
            5'd17:   v = 32'sd1833;
            5'd18:   v = 32'sd917;
            5'd19:   v = 32'sd458;
            5'd20:   v = 32'sd229;
            5'd21:   v = 32'sd115;
            5'd22:   v = 32'sd57;
            5'd23:   v = 32'sd29;
            5'd24:   v = 32'sd14;
            5'd25:   v = 32'sd7;
            5'd26:   v = 32'sd4;
            5'd27:   v = 32'sd2;
            5'd28:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/slor_cordic.sv]
// ----------------------------------------------------------------------------
// slor_cordic
// Iterative rotation unit: gain scaling on one multiplier, then one
// shift/add/subtract micro-rotation per cycle.
// ----------------------------------------------------------------------------
module slor_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slor_pkg::t_cordic_req i_req,
    output slor_pkg::t_cordic_rsp o_rsp
);
    import slor_pkg::*;

    t_cor_state r_state, n_state;

    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic signed [VEC_W-1:0]  r_x, n_x;
    logic signed [VEC_W-1:0]  r_y, n_y;
    logic signed [ANG_W-1:0]  r_z, n_z;
    logic [IDX_W-1:0]         r_idx, n_idx;

    // shared gain multiplier
    logic signed [DIFF_W-1:0] g_op;
    logic                     g_neg;
    logic [DIFF_W-1:0]        g_mag;
    logic [62:0]              g_prod;
    logic [62:0]              g_rnd;
    logic [DIFF_W-1:0]        g_res;
    logic signed [VEC_W-1:0]  g_out;

    // micro-rotation unit
    logic signed [VEC_W-1:0]  xs, ys;
    logic signed [ANG_W-1:0]  at;

    // gain scaling, rounded half away from zero
    always_comb begin
        g_op   = (r_state == COR_GAINX) ? r_dx : r_dy;
        g_neg  = g_op[DIFF_W-1];
        g_mag  = g_neg ? DIFF_W'(-g_op) : DIFF_W'(g_op);
        g_prod = 63'(g_mag) * 63'(GAIN_Q30);
        g_rnd  = g_prod + (63'(1) << 29);
        g_res  = g_rnd[62:30];
        g_out  = g_neg ? -$signed({3'b000, g_res}) : $signed({3'b000, g_res});
    end

    // arithmetic shifts and table entry for this step
    always_comb begin
        xs = r_x >>> r_idx;
        ys = r_y >>> r_idx;
        at = atan_entry(r_idx);
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= COR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_idx <= n_idx;
        if (r_state == COR_IDLE && i_req.start) begin
            r_dx <= i_req.dx;
            r_dy <= i_req.dy;
        end
    end

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_idx   = r_idx;
        unique case (r_state)
            COR_IDLE: begin
                if (i_req.start) begin
                    n_z     = i_req.z0;
                    n_idx   = '0;
                    n_state = COR_GAINX;
                end
            end
            COR_GAINX: begin
                n_x     = g_out;
                n_state = COR_GAINY;
            end
            COR_GAINY: begin
                n_y     = g_out;
                n_state = COR_ITER;
            end
            COR_ITER: begin
                if (!r_z[ANG_W-1]) begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - at;
                end else begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + at;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = COR_DONE;
                end
            end
            COR_DONE: begin
                n_state = COR_IDLE;
            end
            default: begin
                n_state = COR_IDLE;
            end
        endcase
    end

    assign o_rsp.done = (r_state == COR_DONE);
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;

endmodule

[hw/rtl/slew_limited_orbit_rotator_core.sv]
// ----------------------------------------------------------------------------
// slew_limited_orbit_rotator_core
// Per-frame camera angle slew toward a button-selected target and rotation
// of the eye point about the pivot by the resulting angle.
// ----------------------------------------------------------------------------
//  channel   direction  protocol  contents
//  s_axis    in         stream    buttons, frame time, eye xyz, pivot xy
//  m_axis    out        stream    rotated eye xyz, current angle
//  apb       in/out     apb       slew_speed at byte address 0
//
//  with a nonzero angle a frame passes through the step multiply, the angle
//  update, two gain multiplies, 16 micro-rotations and a done state on the
//  cordic unit, then the output load; the next frame is accepted once the
//  sequencer is back in idle. a zero angle skips the cordic.
//  s_axis_tready is high only while the sequencer is idle; a result waiting
//  on m_axis does not block acceptance, only the next output load.
//  reset clears the angle, the sequencer and sets slew_speed to 90 deg/s.
// ----------------------------------------------------------------------------
module slew_limited_orbit_rotator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left[0] right[1] back[2] frame_time[18:3] eye_x[50:19] eye_y[82:51]
    // eye_z[114:83] pivot_x[146:115] pivot_y[178:147] zero[183:179]
    input  logic [183:0] s_axis_tdata,
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_eye_x[31:0] new_eye_y[63:32] new_eye_z[95:64] current_angle[111:96]
    output logic [111:0] m_axis_tdata
);
    import slor_pkg::*;

    t_state r_state, n_state;

    logic [23:0]        r_speed;
    logic signed [15:0] r_angle, n_angle;

    // latched frame
    logic signed [15:0] r_target;
    logic [15:0]        r_ft;
    logic signed [31:0] r_ex, r_ey, r_ez, r_px, r_py;

    // slew step
    logic [39:0]        step_prod;
    logic [23:0]        r_step;
    logic signed [16:0] r_diff;
    logic [16:0]        absd;

    // rotation unit
    t_cordic_req        req;
    t_cordic_rsp        rsp;

    // output register
    logic               r_out_valid;
    logic [111:0]       r_out_data;
    logic               out_load;
    logic signed [31:0] res_x, res_y;

    logic               in_accept;
    logic signed [15:0] in_target;

    // saturate a vector component plus pivot to 32 bits
    function automatic logic signed [31:0] sat_add(input logic signed [VEC_W-1:0] v,
                                                   input logic signed [31:0] p);
        logic signed [VEC_W:0] s;
        s = {v[VEC_W-1], v} + (VEC_W+1)'(p);
        if (s > (VEC_W+1)'(32'sh7fffffff)) begin
            return 32'sh7fffffff;
        end else if (s < -(VEC_W+1)'(33'sh080000000)) begin
            return 32'sh80000000;
        end else begin
            return s[31:0];
        end
    endfunction

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLEW_SPEED) ? {8'h00, r_speed} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SLEW_SPEED_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_SLEW_SPEED) begin
            r_speed <= pwdata[23:0];
        end
    end

    // target select: left over right over back
    always_comb begin
        priority if (s_axis_tdata[0]) begin
            in_target = ANGLE_LEFT;
        end else if (s_axis_tdata[1]) begin
            in_target = ANGLE_RIGHT;
        end else if (s_axis_tdata[2]) begin
            in_target = ANGLE_BACK;
        end else begin
            in_target = ANGLE_ZERO;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // frame capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_target <= in_target;
            r_ft     <= s_axis_tdata[18:3];
            r_ex     <= s_axis_tdata[50:19];
            r_ey     <= s_axis_tdata[82:51];
            r_ez     <= s_axis_tdata[114:83];
            r_px     <= s_axis_tdata[146:115];
            r_py     <= s_axis_tdata[178:147];
        end
    end

    // step multiply and difference
    assign step_prod = 40'(r_speed) * 40'(r_ft);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_STEP) begin
            r_step <= step_prod[39:16];
            r_diff <= {r_target[15], r_target} - {r_angle[15], r_angle};
        end
    end

    assign absd = r_diff[16] ? 17'(-r_diff) : 17'(r_diff);

    // angle update: hold in deadband, snap on overshoot, else move by step
    always_comb begin
        n_angle = r_angle;
        if (absd > DEADBAND_UNITS) begin
            if (r_step > 24'(absd)) begin
                n_angle = r_target;
            end else if (!r_diff[16]) begin
                n_angle = r_angle + $signed(r_step[15:0]);
            end else begin
                n_angle = r_angle - $signed(r_step[15:0]);
            end
        end
    end

    // rotation request
    always_comb begin
        req.start = (r_state == ST_MOVE) && (n_angle != 16'sd0);
        req.dx    = {r_ex[31], r_ex} - {r_px[31], r_px};
        req.dy    = {r_ey[31], r_ey} - {r_py[31], r_py};
        req.z0    = {{2{n_angle[15]}}, n_angle, 14'b0};
    end

    slor_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // state and angle registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_angle <= 16'sd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MOVE) begin
                r_angle <= n_angle;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_state = ST_MOVE;
            end
            ST_MOVE: begin
                n_state = req.start ? ST_ROT : ST_OUT;
            end
            ST_ROT: begin
                if (rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result values: pass-through at zero angle
    always_comb begin
        if (r_angle == 16'sd0) begin
            res_x = r_ex;
            res_y = r_ey;
        end else begin
            res_x = sat_add(rsp.x, r_px);
            res_y = sat_add(rsp.y, r_py);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {r_angle, r_ez, res_y, res_x};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slew-limited orbit rotator. A walked table of
// directed frames, then random frame sequences under several speed settings
// and idle patterns on both stream sides. Every output transaction is
// compared with a scoreboard fed by a bit-exact model of the angle slew and
// the fixed-point rotation, or by a typed result for some directed frames.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // button codes, packed as {back, right, left}
    localparam logic [2:0] BTN_NONE  = 3'b000;
    localparam logic [2:0] BTN_LEFT  = 3'b001;
    localparam logic [2:0] BTN_RIGHT = 3'b010;
    localparam logic [2:0] BTN_BACK  = 3'b100;

    // register map
    localparam logic [2:0] ADDR_SLEW_SPEED = 3'(4 * slor_pkg::REG_SLEW_SPEED);
    localparam logic [2:0] ADDR_UNUSED     = 3'd4;

    localparam int ROT_ITERS    = (slor_pkg::CORDIC_STEPS > 30) ? 30 : slor_pkg::CORDIC_STEPS;
    localparam int NUM_DIR      = 19;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_FRAMES = 140;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    // atan(2^-i) in 2^-22 degree
    localparam longint ATAN_DEG22 [30] = '{
        188743680, 111421900, 58872272, 29884485, 15000234,
        7507429, 3754631, 1877430, 938729, 469366,
        234683, 117342, 58671, 29335, 14668,
        7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14,
        7, 4, 2, 1, 0
    };

    // input transaction, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]         pad;
        logic signed [31:0] pivot_y;
        logic signed [31:0] pivot_x;
        logic signed [31:0] eye_z;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_x;
        logic [15:0]        frame_time;
        logic               back;
        logic               right;
        logic               left;
    } frame_t;

    // output transaction
    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [31:0] eye_z;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_x;
    } orbit_res_t;

    typedef struct {
        logic [2:0]  btn;
        logic [15:0] ft;
        logic [31:0] ex, ey, ez, px, py;
        bit          typed;
        logic [111:0] want;
    } dir_row_t;

    // dut signals
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // left[0] right[1] back[2] frame_time[18:3] eye_x[50:19] eye_y[82:51]
    // eye_z[114:83] pivot_x[146:115] pivot_y[178:147] zero[183:179]
    logic [183:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // new_eye_x[31:0] new_eye_y[63:32] new_eye_z[95:64] current_angle[111:96]
    logic [111:0] m_axis_tdata;

    // model state and scoreboard
    logic [23:0]  slew_rate = slor_pkg::SLEW_SPEED_RESET;
    int           cam_angle = 0;
    orbit_res_t   pending_orbits[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           hold_asks = 0;
    int           hold_taken = 0;
    int           hold_left = 0;

    slew_limited_orbit_rotator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // directed frames, typed results only for the unrotated cases
    dir_row_t dir_rows [NUM_DIR] = '{
        // idle buttons after reset: eye passes through
        '{BTN_NONE, 16'h0000, 32'h0001_8000, 32'hFFFD_C000, 32'h0000_0007,
          32'h0000_0000, 32'h0000_0000, 1'b1,
          {16'h0000, 32'h0000_0007, 32'hFFFD_C000, 32'h0001_8000}},
        '{BTN_NONE, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
          {16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF}},
        '{BTN_NONE, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
          {16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}},
        // zero frame time: no movement yet
        '{BTN_LEFT, 16'h0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 1'b1,
          {16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000}},
        // slow slew toward left, then snap
        '{BTN_LEFT, 16'h0100, 32'h0010_0000, 32'h0000_0000, 32'h0000_0001,
          32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{BTN_LEFT, 16'hFFFF, 32'h0010_0000, 32'h0005_0000, 32'hFFFF_FFFF,
          32'h0001_0000, 32'hFFFF_0000, 1'b0, '0},
        // all buttons: left wins
        '{3'b111, 16'hFFFF, 32'h0003_0000, 32'hFFFE_0000, 32'h1234_5678,
          32'hFFFF_8000, 32'h0000_4000, 1'b0, '0},
        // right over back, partial step
        '{3'b110, 16'hFFFF, 32'h0000_0000, 32'h0004_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        // inside the deadband
        '{BTN_RIGHT, 16'h0010, 32'h0002_0000, 32'h0002_0000, 32'h0000_0000,
          32'h0001_0000, 32'h0001_0000, 1'b0, '0},
        '{BTN_BACK, 16'hFFFF, 32'hFFF0_0000, 32'h0007_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        // back reached, saturating extremes
        '{BTN_BACK, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{BTN_BACK, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
        // land just outside the deadband and creep
        '{BTN_NONE, 16'hFFF8, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{BTN_NONE, 16'h0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{BTN_NONE, 16'h0003, 32'h0100_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{BTN_NONE, 16'hFFFF, 32'h0100_0000, 32'h0100_0000, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        // snap to right with the widest eye-pivot span
        '{BTN_RIGHT, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h5555_5555,
          32'h8000_0000, 32'h8000_0000, 1'b0, '0},
        // back to zero: passthrough again
        '{BTN_NONE, 16'hFFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
          32'h1234_0000, 32'h0000_5678, 1'b1,
          {16'h0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA}},
        '{BTN_NONE, 16'h0000, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h0000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
          {16'h0000, 32'h0000_0000, 32'h0BAD_F00D, 32'hDEAD_BEEF}}
    };

    // round-half-away gain multiply in q30
    function automatic longint gain_scale(input longint v);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(-v) : v;
        q = (mag * 64'(slor_pkg::GAIN_Q30) + (64'd1 << 29)) >> 30;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
        if (v < -longint'(64'h8000_0000)) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // slew the kept angle for one frame and rotate the eye by it
    function automatic orbit_res_t advance_orbit(input frame_t f);
        int         aim;
        int         gap;
        int         mag;
        longint     stride;
        longint     rx;
        longint     ry;
        longint     rz;
        longint     xs;
        longint     ys;
        orbit_res_t r;
        if (f.left) aim = slor_pkg::ANGLE_LEFT;
        else if (f.right) aim = slor_pkg::ANGLE_RIGHT;
        else if (f.back) aim = slor_pkg::ANGLE_BACK;
        else aim = slor_pkg::ANGLE_ZERO;
        gap = aim - cam_angle;
        mag = (gap < 0) ? -gap : gap;
        if (mag > int'(slor_pkg::DEADBAND_UNITS)) begin
            stride = (longint'(slew_rate) * longint'(f.frame_time)) >>> 16;
            if (stride > mag) cam_angle = aim;
            else if (gap > 0) cam_angle += int'(stride);
            else cam_angle -= int'(stride);
        end
        if (cam_angle != 0) begin
            rx = gain_scale(longint'(f.eye_x) - longint'(f.pivot_x));
            ry = gain_scale(longint'(f.eye_y) - longint'(f.pivot_y));
            rz = longint'(cam_angle) * 16384;
            for (int i = 0; i < ROT_ITERS; i++) begin
                xs = rx >>> i;
                ys = ry >>> i;
                if (rz >= 0) begin
                    rx -= ys;
                    ry += xs;
                    rz -= ATAN_DEG22[i];
                end else begin
                    rx += ys;
                    ry -= xs;
                    rz += ATAN_DEG22[i];
                end
            end
            r.eye_x = clip32(rx + longint'(f.pivot_x));
            r.eye_y = clip32(ry + longint'(f.pivot_y));
        end else begin
            r.eye_x = f.eye_x;
            r.eye_y = f.eye_y;
        end
        r.eye_z = f.eye_z;
        r.angle = 16'(cam_angle);
        return r;
    endfunction

    // mostly small coordinates, some full range
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(99) < 80) return 32'($urandom_range(32'h1F_FFFF)) - 32'h10_0000;
        return $urandom();
    endfunction

    function automatic logic [15:0] rand_frame_time();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) return 16'($urandom_range(2047));
        if (pick < 60) return 16'($urandom_range(15));
        if (pick < 90) return 16'($urandom());
        return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t mismatch %s: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // offer one frame, record its expected result on acceptance
    task automatic send_frame(input frame_t f, input bit typed, input orbit_res_t want);
        orbit_res_t calc;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        calc = advance_orbit(f);
        pending_orbits.push_back(typed ? want : calc);
    endtask

    // stop offering and let every outstanding transaction return
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_orbits.size() != 0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_SLEW_SPEED) slew_rate = data[23:0];
    endtask

    task automatic check_speed_readback();
        logic [31:0] seen;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SLEW_SPEED;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        report_field("slew_speed readback", {8'd0, slew_rate}, seen);
    endtask

    // receiver: random stalls plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_asks != hold_taken) begin
            hold_taken    <= hold_asks;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // scoreboard check of each output transaction
    always @(posedge i_clk) begin
        orbit_res_t got;
        orbit_res_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_orbits.size() == 0) begin
                fail_count++;
                $display("%0t unexpected result: expected none, actual %h", $time, got);
            end else begin
                want = pending_orbits.pop_front();
                report_field("new_eye_x", want.eye_x, got.eye_x);
                report_field("new_eye_y", want.eye_y, got.eye_y);
                report_field("new_eye_z", want.eye_z, got.eye_z);
                report_field("current_angle", 32'(want.angle), 32'(got.angle));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("slew_limited_orbit_rotator_core regression: fail");
            $finish;
        end
    end

    initial begin
        frame_t      f;
        logic [2:0]  held_btn;
        logic [23:0] speed;
        held_btn = BTN_NONE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset speed
        check_speed_readback();
        foreach (dir_rows[n]) begin
            f = {5'd0, dir_rows[n].py, dir_rows[n].px, dir_rows[n].ez, dir_rows[n].ey,
                 dir_rows[n].ex, dir_rows[n].ft, dir_rows[n].btn};
            send_frame(f, dir_rows[n].typed, dir_rows[n].want);
        end

        // random phases, each phase sets a speed and an idle pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p)
                0, 7:    speed = slor_pkg::SLEW_SPEED_RESET;
                1:       speed = 24'd0;
                2, 6:    speed = 24'hFF_FFFF;
                3:       speed = 24'($urandom());
                4:       speed = 24'd65536;
                default: speed = 24'($urandom_range(100, 5000));
            endcase
            apb_write(ADDR_SLEW_SPEED, {8'($urandom()), speed});
            if (p == 1) apb_write(ADDR_UNUSED, $urandom());
            check_speed_readback();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            for (int k = 0; k < PHASE_FRAMES; k++) begin
                // long receiver hold-off while frames keep coming
                if (p == 0 && k == 20) hold_asks <= hold_asks + 1;
                // sender pause until every result is back
                if (p == 5 && k == 70) wait_drained();
                if ($urandom_range(99) < 15) held_btn = 3'($urandom_range(7));
                f = {5'd0, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_frame_time(), held_btn};
                send_frame(f, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("slew_limited_orbit_rotator_core regression: pass");
        end else begin
            $display("slew_limited_orbit_rotator_core regression: fail");
        end
        $finish;
    end

endmodule
